// ===== src/vag_pkg.sv =====
// Shared types, constants and coefficient lookup for the VAG ADPCM frame decoder.
package vag_pkg;

    // Width of the saturated history values
    localparam int HIST_W = 40;
    // Product of a history value and an 8-bit coefficient
    localparam int PROD_W = HIST_W + 8;
    // Accumulator: holds two products plus the scaled nibble for fraction bits up to 24
    localparam int ACC_W  = 50;
    // Entries in the front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    // Highest valid predictor index
    localparam logic [3:0] PRED_MAX = 4'd4;

    // One data byte handed from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] pred;
        logic [3:0] shift;
        logic       last;
        logic       bad;
    } entry_t;

    // Coefficient on the most recent history value (in 64ths)
    function automatic logic signed [7:0] coef_recent(input logic [3:0] idx);
        logic signed [7:0] k;
        unique case (idx)
            4'd1:    k = 8'sd60;
            4'd2:    k = 8'sd115;
            4'd3:    k = 8'sd98;
            4'd4:    k = 8'sd122;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

    // Coefficient on the older history value (in 64ths)
    function automatic logic signed [7:0] coef_older(input logic [3:0] idx);
        logic signed [7:0] k;
        unique case (idx)
            4'd2:    k = -8'sd52;
            4'd3:    k = -8'sd55;
            4'd4:    k = -8'sd60;
            default: k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

// ===== src/vag_front.sv =====
// Front end: tracks the frame position, latches the header, queues data bytes.
module vag_front #(
    parameter int SAMPLES_PER_FRAME = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] frame_byte
    input  logic             q_full,
    output logic             q_push,
    output vag_pkg::entry_t  q_entry
);

    localparam logic [3:0] LAST_POS = 4'(SAMPLES_PER_FRAME / 2 + 1);
    localparam logic [3:0] POS_FLAGS = 4'd1;
    localparam logic [3:0] POS_FIRST_DATA = 4'd2;

    logic [3:0] pos_reg,   pos_next;
    logic [3:0] pred_reg,  pred_next;
    logic [3:0] shift_reg, shift_next;
    logic       accept;
    logic       is_data;
    logic       is_last;

    // Header and flags beats never need queue space
    assign is_data  = (pos_reg >= POS_FIRST_DATA);
    assign s_tready = !is_data || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_last  = (pos_reg >= LAST_POS);
    assign q_push   = accept && is_data;

    always_comb
    begin
        q_entry.data_byte = s_tdata;
        q_entry.pred      = pred_reg;
        q_entry.shift     = shift_reg;
        q_entry.last      = is_last;
        q_entry.bad       = (pred_reg > vag_pkg::PRED_MAX);
    end

    // Position and header tracking
    always_comb
    begin
        pos_next   = pos_reg;
        pred_next  = pred_reg;
        shift_next = shift_reg;
        if (accept)
        begin
            if (pos_reg == 4'd0)
            begin
                pred_next  = s_tdata[7:4];
                shift_next = s_tdata[3:0];
                pos_next   = POS_FLAGS;
            end
            else if (is_last)
            begin
                pos_next = 4'd0;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            pred_reg  <= 4'd0;
            shift_reg <= 4'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            pred_reg  <= pred_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== src/vag_fifo.sv =====
// Two-entry queue between the front end and the sample engine.
module vag_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vag_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output vag_pkg::entry_t  head,
    output logic             empty
);

    vag_pkg::entry_t mem_reg [vag_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg,    cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'(vag_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== src/vag_back.sv =====
// Sample engine: two-tap prediction, rounding and saturation, output register.
module vag_back #(
    parameter int HISTORY_FRACTION_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  vag_pkg::entry_t  head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,    // [15:0] pcm_sample
    output logic             m_tlast,    // frame_end
    output logic             m_tuser     // bad_predictor
);

    localparam int HW = vag_pkg::HIST_W;
    localparam int AW = vag_pkg::ACC_W;
    localparam int RW = AW - 6;
    localparam int F  = HISTORY_FRACTION_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic signed [AW-1:0] ACC_HALF  = AW'(32);
    localparam logic signed [HW:0]   HIST_HALF = (HW+1)'(1) << (F - 1);

    logic [1:0]                      state_reg, state_next;
    vag_pkg::entry_t                 cur_reg;
    logic                            sel_reg;
    logic signed [vag_pkg::PROD_W-1:0] prod1_reg, prod2_reg;
    logic signed [HW-1:0]            hist_recent_reg, hist_older_reg;
    logic                            out_valid_reg;
    logic [15:0]                     out_data_reg;
    logic                            out_last_reg, out_bad_reg;

    logic [3:0]                      nib;
    logic signed [15:0]              nib_scaled;
    logic signed [AW-1:0]            acc;
    logic signed [AW-1:0]            acc_shr;
    logic [RW-1:0]                   rnd;
    logic signed [HW-1:0]            hist_new;
    logic signed [HW:0]              out_sum;
    logic signed [HW:0]              out_shr;
    logic [15:0]                     sample;
    logic                            out_free;
    logic                            load;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && !empty;
    assign load     = (state_reg == S_EMIT) && out_free;

    // Nibble to 16-bit scaled step
    assign nib        = sel_reg ? cur_reg.data_byte[7:4] : cur_reg.data_byte[3:0];
    assign nib_scaled = $signed({nib, 12'h000}) >>> cur_reg.shift;

    // New history: scaled step plus prediction, rounded, saturated to 40 bits
    always_comb
    begin
        acc = (AW'(nib_scaled) <<< (F + 6)) + AW'(prod1_reg) + AW'(prod2_reg) + ACC_HALF;
        acc_shr = acc >>> 6;
        rnd = acc_shr[RW-1:0];
        if ((&rnd[RW-1:HW-1]) || !(|rnd[RW-1:HW-1]))
            hist_new = $signed(rnd[HW-1:0]);
        else
            hist_new = $signed({rnd[RW-1], {(HW-1){~rnd[RW-1]}}});
    end

    // Output sample: round history to integer, saturate to 16 bits
    always_comb
    begin
        out_sum = (HW+1)'(hist_recent_reg) + HIST_HALF;
        out_shr = out_sum >>> F;
        if ((&out_shr[HW:15]) || !(|out_shr[HW:15]))
            sample = out_shr[15:0];
        else
            sample = {out_shr[HW], {15{~out_shr[HW]}}};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!empty) state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                    state_next = sel_reg ? S_IDLE : S_MUL;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (state_reg == S_MUL)
        begin
            prod1_reg <= vag_pkg::PROD_W'(hist_recent_reg)
                       * vag_pkg::PROD_W'(vag_pkg::coef_recent(cur_reg.pred));
            prod2_reg <= vag_pkg::PROD_W'(hist_older_reg)
                       * vag_pkg::PROD_W'(vag_pkg::coef_older(cur_reg.pred));
        end
        if (load)
        begin
            out_data_reg <= sample;
            out_last_reg <= cur_reg.last && sel_reg;
            out_bad_reg  <= cur_reg.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sel_reg         <= 1'b0;
            hist_recent_reg <= '0;
            hist_older_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                sel_reg <= 1'b0;
            else if (load)
                sel_reg <= 1'b1;
            if (state_reg == S_ACC)
            begin
                hist_older_reg  <= hist_recent_reg;
                hist_recent_reg <= hist_new;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

endmodule

// ===== src/vag_adpcm_frame_decoder_top.sv =====
// Top level of the VAG ADPCM frame decoder: front end, queue and sample engine.
// Sequence: with the engine idle, a data byte taken into the queue is popped, then runs
// through S_MUL, S_ACC and S_EMIT before m_tvalid rises; its second sample repeats those states.
// Flow: the shared multiply/accumulate loop pops the next byte only after both samples of the
// last one are loaded, and S_EMIT waits on m_tready. Header and flags beats give no samples.
// Reset (rst_n, async, active low) clears frame position, header, history and all valids.
module vag_adpcm_frame_decoder_top #(
    parameter int SAMPLES_PER_FRAME     = 28,
    parameter int HISTORY_FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pcm_sample
    output logic        m_tlast,   // frame_end
    output logic        m_tuser    // bad_predictor
);

    logic            q_push, q_full, q_pop, q_empty;
    vag_pkg::entry_t q_in, q_head;

    vag_front #(
        .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    vag_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    vag_back #(
        .HISTORY_FRACTION_BITS(HISTORY_FRACTION_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // Engine never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // A pop starts a sample sequence, so no second pop follows immediately
    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("back-to-back queue pops");

endmodule
